@@ design/note_arpeggiator_defines.svh @@
// Assertion helpers for the arpeggiator RTL.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef NOTE_ARPEGGIATOR_DEFINES_SVH
`define NOTE_ARPEGGIATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/arp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package arp_pkg;

  // Note list geometry.
  localparam int MAX_NOTES  = 4;
  localparam int NOTE_W     = 7;
  localparam int IN_NOTE_W  = 8;
  localparam int CNT_W      = 3;
  localparam int POS_W      = 2;

  // Random generator.
  localparam int          LFSR_W     = 16;
  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam int          MOD_DIGITS = LFSR_W / 2;
  localparam int          MOD_CNT_W  = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd1;

  // Note markers and limits.
  localparam logic [IN_NOTE_W-1:0] REST_MARK  = 8'hFF;
  localparam logic [IN_NOTE_W-1:0] NOTE_LIMIT = 8'd127;
  localparam logic [CNT_W-1:0]     OFFERED    = 3'd4;

  typedef logic [NOTE_W-1:0]                 arp_note_t;
  typedef arp_note_t [MAX_NOTES-1:0]         arp_list_t;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_RESTART = 2'd2
  } arp_cmd_e;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_UP       = 3'd1,
    MODE_DOWN     = 3'd2,
    MODE_UPDOWN   = 3'd3,
    MODE_DOWNUP   = 3'd4,
    MODE_RANDOM   = 3'd5,
    MODE_ASPLAYED = 3'd6
  } arp_mode_e;

  // Status returned by the modulo-three unit.
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] rem;
  } arp_mod_rsp_t;

endpackage

`default_nettype wire

@@ design/arp_insert.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One insertion-sort step: drops invalid or repeated notes and inserts the
// rest into the ascending list.
module arp_insert (
  input  wire logic                            en_i,
  input  wire logic [arp_pkg::IN_NOTE_W-1:0]   value_i,
  input  wire arp_pkg::arp_list_t              list_i,
  input  wire logic [arp_pkg::CNT_W-1:0]       count_i,
  output arp_pkg::arp_list_t                   list_o,
  output logic [arp_pkg::CNT_W-1:0]            count_o
);
  import arp_pkg::*;

  logic             dup;
  logic [CNT_W-1:0] lt;
  logic             take;
  arp_note_t        v;

  assign v = value_i[NOTE_W-1:0];

  // Compare against the stored entries: repeats and the insert slot.
  always_comb begin
    dup = 1'b0;
    lt  = '0;
    for (int k = 0; k < MAX_NOTES; k++) begin
      if (CNT_W'(k) < count_i) begin
        if (list_i[k] == v) dup = 1'b1;
        if (list_i[k] < v)  lt  = lt + CNT_W'(1);
      end
    end
  end

  assign take = en_i && (value_i <= NOTE_LIMIT) && !dup;

  // Shift the upper entries up by one and drop the note into its slot.
  always_comb begin
    list_o[0] = (take && lt == '0) ? v : list_i[0];
    for (int k = 1; k < MAX_NOTES; k++) begin
      if (!take || CNT_W'(k) > count_i || CNT_W'(k) < lt) begin
        list_o[k] = list_i[k];
      end else if (CNT_W'(k) == lt) begin
        list_o[k] = v;
      end else begin
        list_o[k] = list_i[k-1];
      end
    end
  end

  assign count_o = count_i + CNT_W'(take);

endmodule

`default_nettype wire

@@ design/arp_mod3.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Remainder of a word by three, one base-4 digit a cycle. Since four is one
// modulo three, the remainder is the digit sum reduced modulo three.
module arp_mod3 (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [arp_pkg::LFSR_W-1:0]     value_i,
  output arp_pkg::arp_mod_rsp_t               rsp_o
);
  import arp_pkg::*;

  logic [LFSR_W-1:0]    sh_q, sh_d;
  logic [POS_W-1:0]     acc_q, acc_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [POS_W:0]       sum;

  // Add the next digit and fold the sum back below three.
  always_comb begin
    sum    = {1'b0, acc_q} + {1'b0, sh_q[POS_W-1:0]};
    sh_d   = sh_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = value_i;
      acc_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = (sum >= 3'd3) ? POS_W'(sum - 3'd3) : sum[POS_W-1:0];
      sh_d  = sh_q >> 2;
      cnt_d = cnt_q + MOD_CNT_W'(1);
      if (cnt_q == MOD_CNT_W'(MOD_DIGITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = acc_q;

endmodule

`default_nettype wire

@@ design/note_arpeggiator.sv @@
// Four-note arpeggiator.
// Input channel: in_valid_i with in_stall_o; each beat carries a command
// (load notes, step, restart) and, for a load, up to four offered notes.
// Output channel: out_valid_o with out_stall_i; each input beat yields exactly
// one output beat with the current note, the rest flag, the stored note count
// and the walk position.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// index 0 sets the mode and restarts the walk, index 1 loads the random seed.
// A load beat runs one insertion step per offered slot in S_LOAD, then
// passes S_WALK and S_DONE to the output register; a new beat can enter
// once its result is written there. Step and restart beats pass S_WALK and
// S_DONE, an unused command S_DONE alone. A random step over three notes
// also waits in S_MOD on the digit-serial modulo unit (eight digits).
// The sequencer works on one beat at a time.
// The output register holds a result while out_stall_i is high; the next
// input beat is still accepted, and its result waits in the final state.
// Reset clears the note list, sets the mode to off, the seed to one and the
// output to empty.
`timescale 1ns / 1ps
`default_nettype none
`include "note_arpeggiator_defines.svh"

module note_arpeggiator (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration write channel.
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [arp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [arp_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Input channel.
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        cmd_i,
  input  wire logic [arp_pkg::IN_NOTE_W-1:0]     note_a_i,
  input  wire logic [arp_pkg::IN_NOTE_W-1:0]     note_b_i,
  input  wire logic [arp_pkg::IN_NOTE_W-1:0]     note_c_i,
  input  wire logic [arp_pkg::IN_NOTE_W-1:0]     note_d_i,
  input  wire logic [2:0]                        load_count_i,
  // Output channel.
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [arp_pkg::NOTE_W-1:0]             note_o,
  output logic                                   rest_o,
  output logic [arp_pkg::CNT_W-1:0]              held_count_o,
  output logic [arp_pkg::POS_W-1:0]              step_index_o
);
  import arp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_WALK = 5'b00100,
    S_MOD  = 5'b01000,
    S_DONE = 5'b10000
  } arp_state_e;

  arp_state_e state_q, state_d;

  logic [1:0]           cmd_q, cmd_d;
  logic [IN_NOTE_W-1:0] offer_q [MAX_NOTES];
  logic [CNT_W-1:0]     limit_q, limit_d;
  logic [POS_W-1:0]     idx_q, idx_d;

  arp_list_t            sorted_q, sorted_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 down_q, down_d;
  logic [IN_NOTE_W-1:0] playing_q, playing_d;
  logic [LFSR_W-1:0]    lfsr_q, lfsr_d;
  logic [2:0]           mode_q, mode_d;

  logic                 out_valid_q, out_valid_d;
  logic [NOTE_W-1:0]    out_note_q, out_note_d;
  logic                 out_rest_q, out_rest_d;
  logic [CNT_W-1:0]     out_count_q, out_count_d;
  logic [POS_W-1:0]     out_pos_q, out_pos_d;

  logic                 in_fire, cfg_fire, out_free;
  arp_list_t            ins_list;
  logic [CNT_W-1:0]     ins_count;
  logic                 mod_start;
  arp_mod_rsp_t         mod_rsp;
  logic [LFSR_W-1:0]    lfsr_next;

  // Restart values for the current list and mode.
  logic [2:0]           rs_mode;
  logic [POS_W-1:0]     rs_pos;
  logic [IN_NOTE_W-1:0] rs_note;
  // Step values.
  logic [POS_W-1:0]     adv_pos;
  logic                 adv_down;
  logic [IN_NOTE_W-1:0] adv_note;
  logic                 adv_mod;
  logic [CNT_W-1:0]     top_idx, up_pos, bp;
  logic [POS_W-1:0]     bpos;
  logic                 bdown;

  // Terms used by the checks.
  logic                 pos_in_list;
  logic                 rest_ok;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Insertion step over the offered note selected by the slot counter.
  arp_insert u_insert (
    .en_i    ({1'b0, idx_q} < limit_q),
    .value_i (offer_q[idx_q]),
    .list_i  (sorted_q),
    .count_i (count_q),
    .list_o  (ins_list),
    .count_o (ins_count)
  );

  arp_mod3 u_mod3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .value_i (lfsr_next),
    .rsp_o   (mod_rsp)
  );

  assign top_idx   = count_q - CNT_W'(1);
  assign lfsr_next = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);

  // A mode write restarts the walk under the mode being written.
  assign rs_mode = (cfg_fire && cfg_index_i == CFG_MODE) ? cfg_data_i[2:0] : mode_q;

  // Restart: position zero, except down mode which starts at the top note.
  always_comb begin
    rs_pos  = '0;
    rs_note = {1'b0, sorted_q[0]};
    if (count_q == '0) begin
      rs_note = REST_MARK;
    end else if (rs_mode == MODE_DOWN) begin
      rs_pos  = top_idx[POS_W-1:0];
      rs_note = {1'b0, sorted_q[top_idx[POS_W-1:0]]};
    end else if (rs_mode == MODE_DOWNUP) begin
      rs_note = {1'b0, sorted_q[top_idx[POS_W-1:0]]};
    end
  end

  // Bounce walk shared by the up-down and down-up modes; the walk always
  // turns upward when it reaches position zero.
  always_comb begin
    bp    = ({1'b0, pos_q} >= count_q) ? '0 : {1'b0, pos_q};
    bdown = down_q;
    if (!down_q || bp == '0) begin
      if (bp + CNT_W'(1) >= count_q) begin
        bp    = count_q - CNT_W'(2);
        bdown = 1'b1;
      end else begin
        bp    = bp + CNT_W'(1);
        bdown = 1'b0;
      end
    end else begin
      bp = bp - CNT_W'(1);
    end
    bpos = bp[POS_W-1:0];
    if (bpos == '0) bdown = 1'b0;
  end

  // One step of the walk for lists of two or more notes.
  always_comb begin
    up_pos   = {1'b0, pos_q} + CNT_W'(1);
    if (up_pos >= count_q) up_pos = up_pos - count_q;
    adv_pos  = pos_q;
    adv_down = down_q;
    adv_note = {1'b0, sorted_q[0]};
    adv_mod  = 1'b0;
    unique case (mode_q)
      MODE_UP, MODE_ASPLAYED: begin
        adv_pos  = up_pos[POS_W-1:0];
        adv_note = {1'b0, sorted_q[up_pos[POS_W-1:0]]};
      end
      MODE_DOWN: begin
        if (pos_q == '0 || {1'b0, pos_q} >= count_q) begin
          adv_pos = top_idx[POS_W-1:0];
        end else begin
          adv_pos = pos_q - POS_W'(1);
        end
        adv_note = {1'b0, sorted_q[adv_pos]};
      end
      MODE_UPDOWN: begin
        adv_pos  = bpos;
        adv_down = bdown;
        adv_note = {1'b0, sorted_q[bpos]};
      end
      MODE_DOWNUP: begin
        adv_pos  = bpos;
        adv_down = bdown;
        adv_note = {1'b0, sorted_q[top_idx[POS_W-1:0] - bpos]};
      end
      MODE_RANDOM: begin
        if (count_q == CNT_W'(3)) begin
          adv_mod = 1'b1;
        end else if (count_q == CNT_W'(2)) begin
          adv_pos = {1'b0, lfsr_next[0]};
        end else begin
          adv_pos = lfsr_next[POS_W-1:0];
        end
        adv_note = {1'b0, sorted_q[adv_pos]};
      end
      default: begin
        adv_note = {1'b0, sorted_q[0]};
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    limit_d     = limit_q;
    idx_d       = idx_q;
    sorted_d    = sorted_q;
    count_d     = count_q;
    pos_d       = pos_q;
    down_d      = down_q;
    playing_d   = playing_q;
    lfsr_d      = lfsr_q;
    mode_d      = mode_q;
    mod_start   = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    out_note_d  = out_note_q;
    out_rest_d  = out_rest_q;
    out_count_d = out_count_q;
    out_pos_d   = out_pos_q;

    unique case (state_q)
      S_IDLE: begin
        if (cfg_fire) begin
          if (cfg_index_i == CFG_MODE) begin
            mode_d    = cfg_data_i[2:0];
            pos_d     = rs_pos;
            down_d    = 1'b0;
            playing_d = rs_note;
          end else if (cfg_index_i == CFG_SEED) begin
            lfsr_d = (cfg_data_i == '0) ? LFSR_W'(1) : cfg_data_i;
          end
        end else if (in_fire) begin
          cmd_d   = cmd_i;
          limit_d = (load_count_i > OFFERED) ? OFFERED : load_count_i;
          idx_d   = '0;
          if (cmd_i == CMD_LOAD) begin
            sorted_d = '0;
            count_d  = '0;
            state_d  = S_LOAD;
          end else if (cmd_i == CMD_STEP || cmd_i == CMD_RESTART) begin
            state_d = S_WALK;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_LOAD: begin
        sorted_d = ins_list;
        count_d  = ins_count;
        idx_d    = idx_q + POS_W'(1);
        if (idx_q == POS_W'(MAX_NOTES - 1)) state_d = S_WALK;
      end
      S_WALK: begin
        state_d = S_DONE;
        if (cmd_q != CMD_STEP) begin
          pos_d     = rs_pos;
          down_d    = 1'b0;
          playing_d = rs_note;
        end else if (count_q == CNT_W'(1)) begin
          playing_d = {1'b0, sorted_q[0]};
        end else if (count_q != '0) begin
          pos_d     = adv_pos;
          down_d    = adv_down;
          playing_d = adv_note;
          if (mode_q == MODE_RANDOM) lfsr_d = lfsr_next;
          if (adv_mod) begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_rsp.done) begin
          pos_d     = mod_rsp.rem;
          playing_d = {1'b0, sorted_q[mod_rsp.rem]};
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rest_d  = (count_q == '0);
          out_note_d  = (count_q == '0) ? '0 : playing_q[NOTE_W-1:0];
          out_count_d = count_q;
          out_pos_d   = pos_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and walk state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      limit_q     <= '0;
      idx_q       <= '0;
      sorted_q    <= '0;
      count_q     <= '0;
      pos_q       <= '0;
      down_q      <= 1'b0;
      playing_q   <= REST_MARK;
      lfsr_q      <= LFSR_W'(1);
      mode_q      <= MODE_OFF;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      limit_q     <= limit_d;
      idx_q       <= idx_d;
      sorted_q    <= sorted_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      down_q      <= down_d;
      playing_q   <= playing_d;
      lfsr_q      <= lfsr_d;
      mode_q      <= mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: offered notes and the output beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      offer_q[0] <= note_a_i;
      offer_q[1] <= note_b_i;
      offer_q[2] <= note_c_i;
      offer_q[3] <= note_d_i;
    end
    out_note_q  <= out_note_d;
    out_rest_q  <= out_rest_d;
    out_count_q <= out_count_d;
    out_pos_q   <= out_pos_d;
  end

  assign out_valid_o  = out_valid_q;
  assign note_o       = out_note_q;
  assign rest_o       = out_rest_q;
  assign held_count_o = out_count_q;
  assign step_index_o = out_pos_q;

  // An empty list keeps position zero; otherwise the position is inside it.
  assign pos_in_list = (count_q == '0) || ({1'b0, pos_q} < count_q);
  assign rest_ok     = out_valid_o && (rest_o == (held_count_o == '0));

  // Checks on the sequencer and the walk state.
  `ARP_ASSERT_SAME(a_accept_idle, in_fire, state_q == S_IDLE && !cfg_fire, "beat taken while busy")
  `ARP_ASSERT_SAME(a_count_max, 1'b1, count_q <= CNT_W'(MAX_NOTES), "note count above capacity")
  `ARP_ASSERT_SAME(a_pos_range, state_q == S_IDLE, pos_in_list, "walk position outside list")
  `ARP_ASSERT_SAME(a_mod_state, mod_rsp.done, state_q == S_MOD, "modulo result outside wait state")
  `ARP_ASSERT_NEXT(a_rest_flag, state_q == S_DONE && out_free, rest_ok, "rest flag mismatch")

endmodule

`default_nettype wire

@@ test/note_arpeggiator_tb.sv @@
`timescale 1ns / 1ps

module note_arpeggiator_tb;
  import arp_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 9;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_ITEMS  = 1950;
  localparam int NOTE_SLOTS    = 4;
  localparam int LOAD_SLOTS    = 4;

  // Codes the package leaves unnamed, and local copies of package constants.
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [2:0]  MODE_UNUSED = 3'd7;
  localparam logic [15:0] SHIFT_TAPS  = 16'hB400;
  localparam logic [7:0]  NO_NOTE     = 8'hFF;
  localparam logic [7:0]  TOP_NOTE    = 8'd127;

  typedef struct packed {
    logic [6:0] note;
    logic       rest;
    logic [2:0] held;
    logic [1:0] pos;
  } arp_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [1:0] cmd;
  logic [7:0] note_a;
  logic [7:0] note_b;
  logic [7:0] note_c;
  logic [7:0] note_d;
  logic [2:0] load_count;
  logic out_valid;
  logic out_stall;
  logic [NOTE_W-1:0] out_note;
  logic out_rest;
  logic [CNT_W-1:0] out_held;
  logic [POS_W-1:0] out_pos;

  // Expected state of the arpeggiator.
  logic [6:0]  held_notes [NOTE_SLOTS];
  logic [2:0]  held_num;
  logic [1:0]  walk_pos;
  logic        walk_down;
  logic [7:0]  now_playing;
  logic [15:0] lfsr_state;
  logic [2:0]  mode_reg;

  arp_result_t pending_notes[$];
  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  int cycle_count = 0;
  int hold_token = 0;

  note_arpeggiator dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .note_a_i     (note_a),
    .note_b_i     (note_b),
    .note_c_i     (note_c),
    .note_d_i     (note_d),
    .load_count_i (load_count),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .note_o       (out_note),
    .rest_o       (out_rest),
    .held_count_o (out_held),
    .step_index_o (out_pos)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Put the walk back to its starting point for the current mode.
  function automatic void rewind_walk();
    walk_pos  = 2'd0;
    walk_down = 1'b0;
    if (held_num == 3'd0) begin
      now_playing = NO_NOTE;
    end else if (mode_reg == MODE_DOWN) begin
      walk_pos    = 2'(held_num - 3'd1);
      now_playing = {1'b0, held_notes[walk_pos]};
    end else if (mode_reg == MODE_DOWNUP) begin
      now_playing = {1'b0, held_notes[held_num - 3'd1]};
    end else begin
      now_playing = {1'b0, held_notes[0]};
    end
  endfunction

  // Filter, dedupe and insertion-sort the offered notes.
  function automatic void load_held_notes(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d,
                                          input logic [2:0] cnt);
    logic [7:0] offered [LOAD_SLOTS];
    int limit;
    int j;
    bit dup;
    offered[0] = a;
    offered[1] = b;
    offered[2] = c;
    offered[3] = d;
    limit = cnt;
    if (limit > LOAD_SLOTS) limit = LOAD_SLOTS;
    held_num = 3'd0;
    for (int i = 0; i < NOTE_SLOTS; i++) held_notes[i] = 7'd0;
    for (int i = 0; i < limit; i++) begin
      dup = 1'b0;
      for (int k = 0; k < held_num; k++)
        if ({1'b0, held_notes[k]} == offered[i]) dup = 1'b1;
      if (offered[i] <= TOP_NOTE && !dup) begin
        j = held_num;
        while (j > 0 && {1'b0, held_notes[j-1]} > offered[i]) begin
          held_notes[j] = held_notes[j-1];
          j--;
        end
        held_notes[j] = offered[i][6:0];
        held_num = held_num + 3'd1;
      end
    end
    rewind_walk();
  endfunction

  // Up-down position update; reaching the bottom always turns upward.
  function automatic void bounce_walk_pos();
    int pos;
    int n;
    pos = walk_pos;
    n   = held_num;
    if (pos >= n) pos = 0;
    if (!walk_down || pos == 0) begin
      if (pos + 1 >= n) begin
        pos       = n - 2;
        walk_down = 1'b1;
      end else begin
        pos++;
        walk_down = 1'b0;
      end
    end else begin
      pos--;
    end
    if (pos == 0) walk_down = 1'b0;
    walk_pos = 2'(pos);
  endfunction

  // One step of the walk in the configured mode.
  function automatic void step_walk();
    int n;
    int pos;
    logic lsb;
    n   = held_num;
    pos = walk_pos;
    if (n == 0) return;
    if (n == 1) begin
      now_playing = {1'b0, held_notes[0]};
      return;
    end
    case (mode_reg)
      MODE_UP, MODE_ASPLAYED: begin
        pos         = (pos + 1) % n;
        walk_pos    = 2'(pos);
        now_playing = {1'b0, held_notes[pos]};
      end
      MODE_DOWN: begin
        if (pos == 0 || pos >= n) pos = n - 1;
        else pos--;
        walk_pos    = 2'(pos);
        now_playing = {1'b0, held_notes[pos]};
      end
      MODE_UPDOWN: begin
        bounce_walk_pos();
        now_playing = {1'b0, held_notes[walk_pos]};
      end
      MODE_DOWNUP: begin
        bounce_walk_pos();
        now_playing = {1'b0, held_notes[n - 1 - int'(walk_pos)]};
      end
      MODE_RANDOM: begin
        lsb        = lfsr_state[0];
        lfsr_state = lfsr_state >> 1;
        if (lsb) lfsr_state = lfsr_state ^ SHIFT_TAPS;
        pos         = int'(lfsr_state) % n;
        walk_pos    = 2'(pos);
        now_playing = {1'b0, held_notes[pos]};
      end
      default: begin
        now_playing = {1'b0, held_notes[0]};
      end
    endcase
  endfunction

  // Apply one accepted beat and queue the result it must produce.
  function automatic void play_item(input logic [1:0] c, input logic [7:0] a,
                                    input logic [7:0] b, input logic [7:0] n3,
                                    input logic [7:0] n4, input logic [2:0] cnt);
    arp_result_t r;
    case (c)
      CMD_LOAD:    load_held_notes(a, b, n3, n4, cnt);
      CMD_STEP:    step_walk();
      CMD_RESTART: rewind_walk();
      default: ;
    endcase
    r.rest = (held_num == 3'd0);
    r.note = r.rest ? 7'd0 : now_playing[6:0];
    r.held = held_num;
    r.pos  = walk_pos;
    pending_notes.push_back(r);
  endfunction

  // Offer one beat, wait for it to be taken, then maybe idle for a while.
  task automatic send_item(input logic [1:0] c, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] n3, input logic [7:0] n4,
                           input logic [2:0] cnt);
    logic stalled;
    in_valid   <= 1'b1;
    cmd        <= c;
    note_a     <= a;
    note_b     <= b;
    note_c     <= n3;
    note_d     <= n4;
    load_count <= cnt;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    play_item(c, a, b, n3, n4, cnt);
    if (c != CMD_UNUSED) items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end else begin
      burst_left--;
    end
  endtask

  // Stop offering and wait until every result is in and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_notes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One configuration beat; only called while the block is idle.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    logic ready;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      ready = cfg_ready;
      @(posedge clk);
    end while (!ready);
    if (idx == CFG_MODE) begin
      mode_reg = data[2:0];
      rewind_walk();
    end else if (idx == CFG_SEED) begin
      lfsr_state = (data == 16'd0) ? 16'd1 : data;
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Steps, restarts and idle commands on an empty list, then an empty load.
  task automatic test_empty_list();
    send_item(CMD_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(CMD_RESTART, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(CMD_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255, 3'd7);
    send_item(CMD_LOAD, 8'd10, 8'd20, 8'd30, 8'd40, 3'd0);
  endtask

  // Out-of-range notes, extremes, duplicates and a count above four.
  task automatic test_load_filtering();
    send_item(CMD_LOAD, 8'd255, 8'd128, 8'd0, 8'd127, 3'd7);
    send_item(CMD_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(CMD_LOAD, 8'd5, 8'd5, 8'd5, 8'd5, 3'd4);
    send_item(CMD_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
  endtask

  // Up walk wrapping over a sorted list, and two notes alternating up-down.
  task automatic test_walk_modes();
    settle();
    write_register(CFG_MODE, {13'd0, MODE_UP});
    send_item(CMD_LOAD, 8'd90, 8'd60, 8'd30, 8'd10, 3'd4);
    repeat (4) send_item(CMD_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    settle();
    write_register(CFG_MODE, {13'd0, MODE_UPDOWN});
    send_item(CMD_LOAD, 8'd50, 8'd40, 8'd200, 8'd7, 3'd2);
    repeat (3) send_item(CMD_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
  endtask

  // A zero seed, random steps over three notes, and the unused mode.
  task automatic test_seed_and_unused_mode();
    settle();
    write_register(CFG_SEED, 16'd0);
    write_register(CFG_MODE, {13'd0, MODE_RANDOM});
    send_item(CMD_LOAD, 8'd1, 8'd2, 8'd3, 8'd0, 3'd3);
    repeat (3) send_item(CMD_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    settle();
    write_register(CFG_MODE, {13'd0, MODE_UNUSED});
    send_item(CMD_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(CMD_UNUSED, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
    send_item(CMD_RESTART, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
  endtask

  // The receiver holds off for a long stretch while beats keep coming.
  task automatic test_output_hold_off();
    settle();
    write_register(CFG_MODE, {13'd0, MODE_UP});
    hold_token++;
    send_item(CMD_LOAD, 8'd64, 8'd12, 8'd99, 8'd33, 3'd4);
    repeat (30) send_item(CMD_STEP, 8'd0, 8'd0, 8'd0, 8'd0, 3'd0);
  endtask

  // Phases of random traffic, each under a fresh mode and often a fresh seed.
  task automatic test_random_traffic();
    int phase;
    int beats;
    int r;
    logic [2:0] mode;
    logic [15:0] data;
    logic [1:0] c;
    logic [7:0] offer [4];
    logic [2:0] cnt;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      settle();
      mode = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
      data = 16'($urandom);
      data[2:0] = mode;
      write_register(CFG_MODE, data);
      if (phase < 4 || $urandom_range(0, 1) == 0) begin
        r = $urandom_range(0, 3);
        data = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom);
        write_register(CFG_SEED, data);
      end
      beats = $urandom_range(30, 90);
      for (int i = 0; i < beats; i++) begin
        r = $urandom_range(0, 99);
        if (i == 0 || (r >= 70 && r < 82)) c = CMD_LOAD;
        else if (r < 70) c = CMD_STEP;
        else if (r < 95) c = CMD_RESTART;
        else c = CMD_UNUSED;
        for (int k = 0; k < 4; k++) begin
          r = $urandom_range(0, 9);
          if (r == 0) offer[k] = 8'($urandom_range(128, 255));
          else if (r == 1) offer[k] = ($urandom_range(0, 1) == 0) ? 8'd0 : TOP_NOTE;
          else offer[k] = 8'($urandom_range(0, 127));
        end
        if ($urandom_range(0, 3) == 0) begin
          r = $urandom_range(1, 3);
          offer[r] = offer[0];
        end
        cnt = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
                                          : 3'($urandom_range(2, 4));
        send_item(c, offer[0], offer[1], offer[2], offer[3], cnt);
      end
      phase++;
    end
  endtask

  // Receiver stall pattern: changing regimes plus the requested long hold-off.
  always @(posedge clk) begin : stall_pattern
    int regime;
    int regime_left;
    int hold_left;
    int hold_seen;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (regime_left == 0) begin
      regime      = $urandom_range(0, 3);
      regime_left = $urandom_range(20, 200);
    end else begin
      regime_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (regime)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (cycle_count[2:0] < 3'd3);
      endcase
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(negedge clk) begin : check_results
    arp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_notes.size() == 0) begin
        $error("result beat with nothing expected: note %0d rest %0d", out_note, out_rest);
        mismatches++;
      end else begin
        want = pending_notes.pop_front();
        if (out_note !== want.note) begin
          $error("note: expected %0d, got %0d", want.note, out_note);
          mismatches++;
        end
        if (out_rest !== want.rest) begin
          $error("rest: expected %0d, got %0d", want.rest, out_rest);
          mismatches++;
        end
        if (out_held !== want.held) begin
          $error("held_count: expected %0d, got %0d", want.held, out_held);
          mismatches++;
        end
        if (out_pos !== want.pos) begin
          $error("step_index: expected %0d, got %0d", want.pos, out_pos);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    cmd        = CMD_LOAD;
    note_a     = 8'd0;
    note_b     = 8'd0;
    note_c     = 8'd0;
    note_d     = 8'd0;
    load_count = 3'd0;
    out_stall  = 1'b0;
    for (int i = 0; i < NOTE_SLOTS; i++) held_notes[i] = 7'd0;
    held_num    = 3'd0;
    walk_pos    = 2'd0;
    walk_down   = 1'b0;
    now_playing = NO_NOTE;
    lfsr_state  = 16'd1;
    mode_reg    = MODE_OFF;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_load_filtering();
    test_walk_modes();
    test_seed_and_unused_mode();
    test_output_hold_off();
    test_random_traffic();

    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
